// ===== hw/rtl/circular_queue_with_search_top_assert.svh =====
// assertion macros for the circular queue with search
// used by circular_queue_with_search_top, expects clk and rst_n in scope
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH

// property that holds on every clock edge outside reset
`define CQS_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CQS_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CQS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cqs_pkg.sv =====
// shared types and constants for the circular queue with search
// no dependencies
package cqs_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_DEQ_RD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic  load_req;
        logic  enq;
        logic  deq;
        logic  deq_take;
        logic  scan_start;
        logic  scan_run;
        logic  res_set;
        stat_t res_status;
        logic  res_slot_hit;
        logic  out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/cqs_dp.sv =====
// datapath: slot memory, head/tail/occupancy, search pipeline, result and output registers
// depends on cqs_pkg
module cqs_dp
    import cqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic [IDX_W-1:0]         slot,
    output logic [CNT_W-1:0]         count
);

    localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    req_t              req_reg;
    logic [DATA_W-1:0] key_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [IDX_W:0]    scan_idx_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [DATA_W-1:0] rd_data_reg;

    stat_t             res_status_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic [IDX_W-1:0]  res_slot_reg;

    logic              out_valid_reg;
    stat_t             out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]  out_slot_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  rd_addr;
    logic              scan_issue;
    logic [IDX_W:0]    off_raw;
    logic [IDX_W:0]    off;
    logic              occupied;
    logic              out_free;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return (s == LAST_IDX) ? '0 : s + 1'b1;
    endfunction

    assign scan_issue = cmd.scan_run && (scan_idx_reg < DEPTH_X);
    assign mem_we     = cmd.enq;
    assign mem_re     = cmd.deq || scan_issue;
    assign rd_addr    = cmd.deq ? head_reg : scan_idx_reg[IDX_W-1:0];

    // ring offset of the compared slot from head
    always_comb
    begin
        off_raw = {1'b0, cmp_idx_reg} + DEPTH_X - {1'b0, head_reg};
        off     = (off_raw >= DEPTH_X) ? off_raw - DEPTH_X : off_raw;
    end
    assign occupied = CNT_W'(off) < occ_reg;

    assign out_free = !out_valid_reg || out_ready;

    assign sts.req      = req_reg;
    assign sts.full     = (occ_reg == FULL_CNT);
    assign sts.empty    = (occ_reg == '0);
    assign sts.hit      = cmp_vld_reg && occupied && (rd_data_reg == key_reg);
    assign sts.last     = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign sts.out_free = out_free;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (cmd.enq)
        begin
            tail_next = next_slot(tail_reg);
            occ_next  = occ_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            occ_next = occ_reg - 1'b1;
            if (occ_reg == CNT_W'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                head_next = next_slot(head_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= key_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            req_reg       <= REQ_NOP;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            if (cmd.load_req)
            begin
                req_reg <= req_t'(req_type);
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                cmp_vld_reg  <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                cmp_vld_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg <= value;
        end
        if (scan_issue)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= '0;
            res_slot_reg   <= cmd.res_slot_hit ? cmp_idx_reg : '0;
        end
        else if (cmd.deq_take)
        begin
            res_status_reg <= STAT_OK;
            res_data_reg   <= rd_data_reg;
            res_slot_reg   <= '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= occ_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign slot      = out_slot_reg;
    assign count     = out_count_reg;

endmodule

// ===== hw/rtl/cqs_ctrl.sv =====
// controller: request sequencing for enqueue, dequeue and search
// depends on cqs_pkg
module cqs_ctrl
    import cqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = STAT_OK;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_OP;
                end
            end
            ST_OP:
            begin
                state_next = ST_EMIT;
                case (sts.req)
                    REQ_ENQ:
                    begin
                        cmd.res_set = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_status = STAT_OVERFLOW;
                        end
                        else
                        begin
                            cmd.enq = 1'b1;
                        end
                    end
                    REQ_DEQ:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_UNDERFLOW;
                        end
                        else
                        begin
                            cmd.deq    = 1'b1;
                            state_next = ST_DEQ_RD;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                    end
                endcase
            end
            ST_DEQ_RD:
            begin
                cmd.deq_take = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.res_set      = 1'b1;
                    cmd.res_slot_hit = 1'b1;
                    state_next       = ST_EMIT;
                end
                else if (sts.last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/circular_queue_with_search_top.sv =====
// channel   | valid     | ready     | payload
// request   | in_valid  | in_ready  | req_type, value
// result    | out_valid | out_ready | status, data, slot, count
//
// enqueue, overflow, underflow, not-found on empty and no-op go from the op state
// straight to the emit state; dequeue adds a read state (registered read of the slot memory)
// search scans the slots from slot 0 and stops at a hit or after the last slot on a miss,
// one slot compare per cycle from the single memory read port
// reset clears pointers and occupancy; slot memory contents are not reset
// a stalled result holds in the output register; one request in flight at a time
module circular_queue_with_search_top
    import cqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic [IDX_W-1:0]         slot,
    output logic [CNT_W-1:0]         count
);

    `include "circular_queue_with_search_top_assert.svh"

    cmd_t cmd;
    sts_t sts;

    cqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cqs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .slot      (slot),
        .count     (count)
    );

    `CQS_ASSERT_IMPLIES(a_count_range, out_valid, count <= CNT_W'(DEPTH), "count above depth")
    `CQS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready,
        "second request taken while busy")
    `CQS_ASSERT_IMPLIES(a_overflow_full, out_valid && status == STAT_OVERFLOW,
        count == CNT_W'(DEPTH), "overflow while not full")
    `CQS_ASSERT_IMPLIES(a_underflow_empty, out_valid && status == STAT_UNDERFLOW,
        count == '0 && data == '0, "underflow with entries or data")

endmodule
